[src/pssc_pkg.sv]
// shared constants, types and helpers for the path sector splitter
// no dependencies

package pssc_pkg;

    localparam int MAX_WAYPOINTS = 65536;
    localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
    localparam int CNT_W         = IDX_W + 1;
    localparam int POS_W         = 32;
    localparam int CURV_IN_W     = 24;
    localparam int CURV_W        = 23;
    localparam int DIST_W        = 32;
    localparam int SUM_W         = CURV_W + IDX_W;
    localparam int CSQ_W         = 2 * CURV_W;
    localparam int SQ_W          = CSQ_W + IDX_W;
    localparam int KIND_W        = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_WAYPOINTS - 1);
    localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_TWO  = IDX_W'(2);

    localparam logic [CURV_W-1:0] CURV_MAX     = '1;
    localparam logic [CURV_W-1:0] STRAIGHT_LIM = CURV_W'(3277);
    localparam logic [CURV_W-1:0] CORNER_LIM   = CURV_W'(6554);
    localparam logic [CSQ_W-1:0]  CHICANE_VAR  = CSQ_W'(42949673);
    localparam logic [CNT_W-1:0]  CHICANE_MIN_N = CNT_W'(3);

    localparam logic [CURV_W-1:0] RST_CORNER_THR = CURV_W'(6554);
    localparam logic [DIST_W-1:0] RST_MIN_LEN    = DIST_W'(5000);
    localparam logic [DIST_W-1:0] RST_MAX_LEN    = DIST_W'(50000);

    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN    = 2'd2;

    localparam logic [KIND_W-1:0] KIND_STRAIGHT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CORNER   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHICANE  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 2'd3;

    // classified waypoint, front to back
    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [CURV_W-1:0]       abs_curv;
        logic                    corner_flag;
        logic [IDX_W-1:0]        idx;
        logic                    path_end;
    } wp_item_t;

    // everything needed to build one sector record
    typedef struct packed {
        logic [IDX_W-1:0]  first;
        logic [IDX_W-1:0]  last_idx;
        logic [DIST_W-1:0] start_dist;
        logic [DIST_W-1:0] end_dist;
        logic              last;
        logic [CNT_W-1:0]  n;
        logic [SUM_W-1:0]  sum;
        logic [SQ_W-1:0]   sumsq;
        logic [CURV_W-1:0] cmax;
        logic [CURV_W-1:0] cmin;
    } rec_job_t;

    typedef struct packed {
        logic     start;
        rec_job_t job;
    } rec_req_t;

    typedef struct packed {
        logic ready;
    } rec_stat_t;

    // |c| with the most negative code saturated
    function automatic logic [CURV_W-1:0] abs_curv(input logic signed [CURV_IN_W-1:0] c);
        logic [CURV_IN_W-1:0] mag;
        begin
            mag = c[CURV_IN_W-1] ? CURV_IN_W'(-c) : CURV_IN_W'(c);
            abs_curv = mag[CURV_IN_W-1] ? CURV_MAX : mag[CURV_W-1:0];
        end
    endfunction

endpackage

[src/pssc_wp_if.sv]
// waypoint channel: valid, ready and one waypoint
// depends on pssc_pkg

interface pssc_wp_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [pssc_pkg::POS_W-1:0]         x_position;
    logic signed [pssc_pkg::POS_W-1:0]         y_position;
    logic signed [pssc_pkg::CURV_IN_W-1:0]     curvature_in;
    logic                                      path_end;

    modport source (output valid, x_position, y_position, curvature_in, path_end,
                    input ready);
    modport sink   (input valid, x_position, y_position, curvature_in, path_end,
                    output ready);
endinterface

[src/pssc_sec_if.sv]
// sector channel: valid, ready and one sector record
// depends on pssc_pkg

interface pssc_sec_if;
    logic                               valid;
    logic                               ready;
    logic [pssc_pkg::IDX_W-1:0]         first_index;
    logic [pssc_pkg::IDX_W-1:0]         final_index;
    logic [pssc_pkg::DIST_W-1:0]        start_dist_mm;
    logic [pssc_pkg::DIST_W-1:0]        end_dist_mm;
    logic [pssc_pkg::DIST_W-1:0]        span_mm;
    logic [pssc_pkg::CURV_W-1:0]        mean_abs_curv;
    logic [pssc_pkg::CURV_W-1:0]        peak_abs_curv;
    logic [pssc_pkg::CURV_W-1:0]        least_abs_curv;
    logic [pssc_pkg::KIND_W-1:0]        sector_kind;
    logic                               last_sector;

    modport source (output valid, first_index, final_index, start_dist_mm, end_dist_mm,
                    span_mm, mean_abs_curv, peak_abs_curv, least_abs_curv, sector_kind,
                    last_sector, input ready);
    modport sink   (input valid, first_index, final_index, start_dist_mm, end_dist_mm,
                    span_mm, mean_abs_curv, peak_abs_curv, least_abs_curv, sector_kind,
                    last_sector, output ready);
endinterface

[src/path_sector_split_curvature_length_core.sv]
// path sector splitter top level: config registers, front, queue, back, record builder
// depends on pssc_pkg, pssc_wp_if, pssc_sec_if, pssc_front, pssc_queue, pssc_back, pssc_rec
// back end: one waypoint at a time, segment length by iterative square root, which the
//   first waypoint of a path skips; each sector holds the record builder and the back
//   end waits while the builder is busy
// record builder: one-bit-a-cycle divider, two 62-step divisions per sector
// reset: rst_n clears all control state at once; no clearing pass, config back to defaults

module path_sector_split_curvature_length_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [pssc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pssc_pkg::CFG_DATA_W-1:0]    cfg_data,
    pssc_wp_if.sink                            waypoint,
    pssc_sec_if.source                         sector
);

    // configuration registers; the user must write them only while the block is idle, the block does not check it
    logic [pssc_pkg::CURV_W-1:0]   corner_thr_reg;
    logic [pssc_pkg::DIST_W-1:0]   min_len_reg;
    logic [pssc_pkg::DIST_W-1:0]   max_len_reg;

    // front to queue
    logic                          push;
    pssc_pkg::wp_item_t            push_item;
    logic                          q_full;

    // queue to back
    logic                          pop;
    pssc_pkg::wp_item_t            q_item;
    logic [pssc_pkg::QCNT_W-1:0]   q_count;
    logic                          q_empty;

    // back to record builder
    pssc_pkg::rec_req_t            rec_req;
    pssc_pkg::rec_stat_t           rec_stat;

    assign q_full  = (q_count == pssc_pkg::QCNT_W'(pssc_pkg::QDEPTH));
    assign q_empty = (q_count == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_thr_reg <= pssc_pkg::RST_CORNER_THR;
            min_len_reg    <= pssc_pkg::RST_MIN_LEN;
            max_len_reg    <= pssc_pkg::RST_MAX_LEN;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                pssc_pkg::CFG_CORNER_THR: corner_thr_reg <= cfg_data[pssc_pkg::CURV_W-1:0];
                pssc_pkg::CFG_MIN_LEN:    min_len_reg    <= cfg_data;
                pssc_pkg::CFG_MAX_LEN:    max_len_reg    <= cfg_data;
                default:                  corner_thr_reg <= corner_thr_reg;
            endcase
        end
    end

    // front: numbers waypoints, folds |curvature| and flags corners
    pssc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .wp               (waypoint),
        .corner_threshold (corner_thr_reg),
        .full             (q_full),
        .push             (push),
        .push_item        (push_item)
    );

    // decoupling queue so the front keeps taking requests, until the queue is full, while the back grinds
    pssc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (q_item),
        .count     (q_count)
    );

    // back: segment length, split decisions, running statistics, held sector
    pssc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_item        (q_item),
        .pop           (pop),
        .min_length_mm (min_len_reg),
        .max_length_mm (max_len_reg),
        .rec_req       (rec_req),
        .rec_stat      (rec_stat)
    );

    // record builder with the output register
    pssc_rec u_rec (
        .clk      (clk),
        .rst_n    (rst_n),
        .rec_req  (rec_req),
        .rec_stat (rec_stat),
        .sec      (sector)
    );

    // queue never holds more than its depth
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= pssc_pkg::QCNT_W'(pssc_pkg::QDEPTH))
        else $error("queue count beyond depth");

    // a full queue must stall the waypoint channel
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !waypoint.ready)
        else $error("waypoint taken while queue full");

    // back only hands a sector to an idle builder
    a_rec_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        rec_req.start |-> rec_stat.ready)
        else $error("sector job started while builder busy");

    // a started job keeps the builder busy next cycle
    a_rec_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rec_req.start |=> !rec_stat.ready)
        else $error("builder did not take sector job");

endmodule

[src/pssc_front.sv]
// front end: takes waypoint requests, numbers and classifies them
// depends on pssc_pkg and pssc_wp_if

module pssc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    pssc_wp_if.sink                       wp,
    input  logic [pssc_pkg::CURV_W-1:0]   corner_threshold,
    input  logic                          full,
    output logic                          push,
    output pssc_pkg::wp_item_t            push_item
);

    logic [pssc_pkg::IDX_W-1:0] idx_reg;
    logic [pssc_pkg::IDX_W-1:0] idx_next;
    logic [pssc_pkg::CURV_W-1:0] ac;
    logic                        is_end;

    assign wp.ready = !full;
    assign push     = wp.valid && !full;

    assign ac     = pssc_pkg::abs_curv(wp.curvature_in);
    // overlong path closes on its last possible index
    assign is_end = wp.path_end || (idx_reg == pssc_pkg::IDX_LAST);

    always_comb
    begin
        push_item.x           = wp.x_position;
        push_item.y           = wp.y_position;
        push_item.abs_curv    = ac;
        push_item.corner_flag = ac > corner_threshold;
        push_item.idx         = idx_reg;
        push_item.path_end    = is_end;
        idx_next = idx_reg;
        if (push)
        begin
            idx_next = is_end ? '0 : idx_reg + pssc_pkg::IDX_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

[src/pssc_queue.sv]
// short queue of classified waypoints between front and back
// depends on pssc_pkg

module pssc_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  pssc_pkg::wp_item_t            push_item,
    input  logic                          pop,
    output pssc_pkg::wp_item_t            pop_item,
    output logic [pssc_pkg::QCNT_W-1:0]   count
);

    pssc_pkg::wp_item_t              mem_reg [pssc_pkg::QDEPTH];
    logic [pssc_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [pssc_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [pssc_pkg::QCNT_W-1:0]     count_reg;

    function automatic logic [pssc_pkg::QPTR_W-1:0] ptr_inc(
        input logic [pssc_pkg::QPTR_W-1:0] p);
        begin
            ptr_inc = (p == pssc_pkg::QPTR_W'(pssc_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
        end
    endfunction

    assign pop_item = mem_reg[rd_ptr_reg];
    assign count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/pssc_back.sv]
// back end: segment length by iterative square root, sector split decisions,
// curvature statistics; depends on pssc_pkg

module pssc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  pssc_pkg::wp_item_t            q_item,
    output logic                          pop,
    input  logic [pssc_pkg::DIST_W-1:0]   min_length_mm,
    input  logic [pssc_pkg::DIST_W-1:0]   max_length_mm,
    output pssc_pkg::rec_req_t            rec_req,
    input  pssc_pkg::rec_stat_t           rec_stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PRE   = 4'd1;
    localparam logic [3:0] S_START = 4'd2;
    localparam logic [3:0] S_MULX  = 4'd3;
    localparam logic [3:0] S_MULY  = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_SQRT  = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_CUT   = 4'd8;
    localparam logic [3:0] S_ADD   = 4'd9;
    localparam logic [3:0] S_END   = 4'd10;

    localparam int RAD_W  = 2 * pssc_pkg::POS_W;
    localparam int REM_W  = pssc_pkg::POS_W + 2;
    localparam int TRY_W  = REM_W + 2;
    localparam int ITER   = RAD_W / 4;
    localparam int ITER_W = $clog2(ITER);

    logic [3:0]                      state_reg;
    pssc_pkg::wp_item_t              cur_reg;
    logic [pssc_pkg::CSQ_W-1:0]      cur_sq_reg;
    logic [pssc_pkg::POS_W-1:0]      prev_x_reg, prev_y_reg;
    logic [pssc_pkg::CURV_W-1:0]     prev_ac_reg;
    logic [pssc_pkg::CSQ_W-1:0]      prev_sq_reg;
    logic                            corner_reg;
    logic [pssc_pkg::DIST_W-1:0]     total_reg, ptot_reg, sd_reg, run_reg, seg_reg;
    logic [pssc_pkg::IDX_W-1:0]      first_reg;
    logic [pssc_pkg::CNT_W-1:0]      n_reg;
    logic [pssc_pkg::SUM_W-1:0]      sum_reg;
    logic [pssc_pkg::SQ_W-1:0]       sumsq_reg;
    logic [pssc_pkg::CURV_W-1:0]     cmax_reg, cmin_reg;
    logic                            held_reg;
    pssc_pkg::rec_job_t              held_job_reg;
    logic [pssc_pkg::POS_W-1:0]      ax_reg, ay_reg;
    logic [RAD_W-1:0]                sx_reg, sy_reg, rad_reg;
    logic                            sat_reg;
    logic [REM_W-1:0]                rem_reg;
    logic [pssc_pkg::POS_W-1:0]      root_reg;
    logic [ITER_W-1:0]               cnt_reg;

    logic [pssc_pkg::POS_W-1:0]      mul_op;
    logic [RAD_W-1:0]                prod;
    logic [RAD_W:0]                  rad_sum;
    logic [pssc_pkg::POS_W:0]        dx, dy;
    logic [REM_W-1:0]                rem_a, rem_b;
    logic [pssc_pkg::POS_W-1:0]      root_a, root_b;
    logic [pssc_pkg::DIST_W-1:0]     seg;
    logic                            cut;
    pssc_pkg::rec_job_t              job_now;
    pssc_pkg::rec_job_t              job_end;

    function automatic logic [pssc_pkg::DIST_W-1:0] sat_add(
        input logic [pssc_pkg::DIST_W-1:0] a, input logic [pssc_pkg::DIST_W-1:0] b);
        logic [pssc_pkg::DIST_W:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[pssc_pkg::DIST_W] ? '1 : s[pssc_pkg::DIST_W-1:0];
        end
    endfunction

    // one digit of the square root; result bit goes into root lsb
    function automatic logic [REM_W+pssc_pkg::POS_W-1:0] sqrt_step(
        input logic [REM_W-1:0] rem, input logic [pssc_pkg::POS_W-1:0] root,
        input logic [1:0] bits);
        logic [TRY_W-1:0] r2;
        logic [TRY_W-1:0] trial;
        logic [TRY_W-1:0] diff;
        begin
            r2    = {rem, bits};
            trial = {root, 2'b01};
            diff  = r2 - trial;
            if (r2 >= trial)
            begin
                sqrt_step = {diff[REM_W-1:0], root[pssc_pkg::POS_W-2:0], 1'b1};
            end
            else
            begin
                sqrt_step = {r2[REM_W-1:0], root[pssc_pkg::POS_W-2:0], 1'b0};
            end
        end
    endfunction

    assign mul_op  = (state_reg == S_MULX) ? ax_reg : ay_reg;
    assign prod    = mul_op * mul_op;
    assign rad_sum = {1'b0, sx_reg} + {1'b0, sy_reg};
    assign dx      = {cur_reg.x[pssc_pkg::POS_W-1], cur_reg.x}
                   - {prev_x_reg[pssc_pkg::POS_W-1], prev_x_reg};
    assign dy      = {cur_reg.y[pssc_pkg::POS_W-1], cur_reg.y}
                   - {prev_y_reg[pssc_pkg::POS_W-1], prev_y_reg};

    assign {rem_a, root_a} = sqrt_step(rem_reg, root_reg, rad_reg[RAD_W-1 -: 2]);
    assign {rem_b, root_b} = sqrt_step(rem_a, root_a, rad_reg[RAD_W-3 -: 2]);

    assign seg = sat_reg ? '1 : root_reg;
    assign cut = ((cur_reg.corner_flag != corner_reg) && (run_reg >= min_length_mm))
              || (run_reg >= max_length_mm);

    always_comb
    begin
        job_now.first      = first_reg;
        job_now.last_idx   = cur_reg.idx - pssc_pkg::IDX_ONE;
        job_now.start_dist = sd_reg;
        job_now.end_dist   = ptot_reg;
        job_now.last       = 1'b0;
        job_now.n          = n_reg;
        job_now.sum        = sum_reg;
        job_now.sumsq      = sumsq_reg;
        job_now.cmax       = cmax_reg;
        job_now.cmin       = cmin_reg;
        job_end            = job_now;
        job_end.last_idx   = cur_reg.idx;
        job_end.end_dist   = total_reg;
        job_end.last       = 1'b1;
    end

    assign pop = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        rec_req.start = 1'b0;
        rec_req.job   = job_now;
        case (state_reg)
            S_PRE:
            begin
                rec_req.job   = held_job_reg;
                rec_req.start = (cur_reg.idx == pssc_pkg::IDX_TWO) && held_reg
                              && rec_stat.ready;
            end
            S_CUT:
            begin
                rec_req.start = cut && (cur_reg.idx != pssc_pkg::IDX_ONE) && rec_stat.ready;
            end
            S_END:
            begin
                rec_req.job   = job_end;
                rec_req.start = cur_reg.path_end && (cur_reg.idx >= pssc_pkg::IDX_TWO)
                              && rec_stat.ready;
            end
            default:
            begin
                rec_req.start = 1'b0;
            end
        endcase
    end

    // payload and statistics registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cur_reg <= q_item;
            end
            S_PRE:
            begin
                cur_sq_reg <= cur_reg.abs_curv * cur_reg.abs_curv;
            end
            S_START:
            begin
                ax_reg <= dx[pssc_pkg::POS_W] ? pssc_pkg::POS_W'(-dx) : dx[pssc_pkg::POS_W-1:0];
                ay_reg <= dy[pssc_pkg::POS_W] ? pssc_pkg::POS_W'(-dy) : dy[pssc_pkg::POS_W-1:0];
                if (cur_reg.idx == '0)
                begin
                    corner_reg <= cur_reg.corner_flag;
                    n_reg      <= pssc_pkg::CNT_W'(1);
                    sum_reg    <= pssc_pkg::SUM_W'(cur_reg.abs_curv);
                    sumsq_reg  <= pssc_pkg::SQ_W'(cur_sq_reg);
                    cmax_reg   <= cur_reg.abs_curv;
                    cmin_reg   <= cur_reg.abs_curv;
                    first_reg  <= '0;
                    sd_reg     <= '0;
                    total_reg  <= '0;
                    run_reg    <= '0;
                end
            end
            S_MULX:
            begin
                sx_reg <= prod;
            end
            S_MULY:
            begin
                sy_reg <= prod;
            end
            S_SUM:
            begin
                sat_reg  <= rad_sum[RAD_W];
                rad_reg  <= rad_sum[RAD_W-1:0];
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= ITER_W'(ITER - 1);
            end
            S_SQRT:
            begin
                // two root digits a cycle, four radicand bits consumed
                rem_reg  <= rem_b;
                root_reg <= root_b;
                rad_reg  <= {rad_reg[RAD_W-5:0], 4'b0};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            S_UPD:
            begin
                seg_reg   <= seg;
                ptot_reg  <= total_reg;
                total_reg <= sat_add(total_reg, seg);
                run_reg   <= sat_add(run_reg, seg);
            end
            S_CUT:
            begin
                if (cut && ((cur_reg.idx == pssc_pkg::IDX_ONE) || rec_stat.ready))
                begin
                    if (cur_reg.idx == pssc_pkg::IDX_ONE)
                    begin
                        held_job_reg <= job_now;
                    end
                    first_reg  <= cur_reg.idx - pssc_pkg::IDX_ONE;
                    sd_reg     <= ptot_reg;
                    run_reg    <= seg_reg;
                    corner_reg <= cur_reg.corner_flag;
                    n_reg      <= pssc_pkg::CNT_W'(1);
                    sum_reg    <= pssc_pkg::SUM_W'(prev_ac_reg);
                    sumsq_reg  <= pssc_pkg::SQ_W'(prev_sq_reg);
                    cmax_reg   <= prev_ac_reg;
                    cmin_reg   <= prev_ac_reg;
                end
            end
            S_ADD:
            begin
                n_reg     <= n_reg + 1'b1;
                sum_reg   <= sum_reg + pssc_pkg::SUM_W'(cur_reg.abs_curv);
                sumsq_reg <= sumsq_reg + pssc_pkg::SQ_W'(cur_sq_reg);
                if (cur_reg.abs_curv > cmax_reg)
                begin
                    cmax_reg <= cur_reg.abs_curv;
                end
                if (cur_reg.abs_curv < cmin_reg)
                begin
                    cmin_reg <= cur_reg.abs_curv;
                end
            end
            S_END:
            begin
                prev_x_reg  <= cur_reg.x;
                prev_y_reg  <= cur_reg.y;
                prev_ac_reg <= cur_reg.abs_curv;
                prev_sq_reg <= cur_sq_reg;
            end
            default:
            begin
                sat_reg <= sat_reg;
            end
        endcase
    end

    // control: sequencer and held-sector flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_PRE;
                    end
                end
                S_PRE:
                begin
                    if (!((cur_reg.idx == pssc_pkg::IDX_TWO) && held_reg))
                    begin
                        state_reg <= S_START;
                    end
                    else if (rec_stat.ready)
                    begin
                        held_reg  <= 1'b0;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    if (cur_reg.idx == '0)
                    begin
                        held_reg  <= 1'b0;
                        state_reg <= S_END;
                    end
                    else
                    begin
                        state_reg <= S_MULX;
                    end
                end
                S_MULX:
                begin
                    state_reg <= S_MULY;
                end
                S_MULY:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    state_reg <= S_CUT;
                end
                S_CUT:
                begin
                    if (!cut)
                    begin
                        state_reg <= S_ADD;
                    end
                    else if (cur_reg.idx == pssc_pkg::IDX_ONE)
                    begin
                        held_reg  <= 1'b1;
                        state_reg <= S_ADD;
                    end
                    else if (rec_stat.ready)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    state_reg <= S_END;
                end
                S_END:
                begin
                    if (!cur_reg.path_end)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if ((cur_reg.idx < pssc_pkg::IDX_TWO) || rec_stat.ready)
                    begin
                        held_reg  <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/pssc_rec.sv]
// sector record builder: serial divider for mean and mean square, kind
// decision and output register; depends on pssc_pkg and pssc_sec_if

module pssc_rec (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pssc_pkg::rec_req_t   rec_req,
    output pssc_pkg::rec_stat_t  rec_stat,
    pssc_sec_if.source           sec
);

    localparam logic [2:0] R_IDLE = 3'd0;
    localparam logic [2:0] R_DIV1 = 3'd1;
    localparam logic [2:0] R_DIV2 = 3'd2;
    localparam logic [2:0] R_SQ   = 3'd3;
    localparam logic [2:0] R_OUT  = 3'd4;

    localparam int DCNT_W = $clog2(pssc_pkg::SQ_W);

    logic [2:0]                       state_reg;
    pssc_pkg::rec_job_t               job_reg;
    logic [pssc_pkg::SQ_W-1:0]        dvd_reg;
    logic [pssc_pkg::CNT_W-1:0]       rem_reg;
    logic [DCNT_W-1:0]                cnt_reg;
    logic [pssc_pkg::CURV_W-1:0]      avg_reg;
    logic [pssc_pkg::CSQ_W-1:0]       avgsq_reg;
    logic                             out_valid_reg;

    logic [pssc_pkg::CNT_W:0]         rem_sh;
    logic                             ge;
    logic [pssc_pkg::CNT_W:0]         rem_diff;
    logic [pssc_pkg::CNT_W-1:0]       rem_n;
    logic [pssc_pkg::SQ_W-1:0]        dvd_n;
    logic [pssc_pkg::CSQ_W-1:0]       var_val;
    logic [pssc_pkg::KIND_W-1:0]      kind;
    logic                             out_free;

    // restoring division, one quotient bit a cycle
    assign rem_sh   = {rem_reg, dvd_reg[pssc_pkg::SQ_W-1]};
    assign ge       = rem_sh >= {1'b0, job_reg.n};
    assign rem_diff = rem_sh - {1'b0, job_reg.n};
    assign rem_n    = ge ? rem_diff[pssc_pkg::CNT_W-1:0] : rem_sh[pssc_pkg::CNT_W-1:0];
    assign dvd_n    = {dvd_reg[pssc_pkg::SQ_W-2:0], ge};

    assign var_val  = dvd_reg[pssc_pkg::CSQ_W-1:0] - avgsq_reg;
    assign out_free = !out_valid_reg || sec.ready;

    always_comb
    begin
        if (avg_reg < pssc_pkg::STRAIGHT_LIM)
        begin
            kind = pssc_pkg::KIND_STRAIGHT;
        end
        else if ((job_reg.n >= pssc_pkg::CHICANE_MIN_N) && (var_val > pssc_pkg::CHICANE_VAR))
        begin
            kind = pssc_pkg::KIND_CHICANE;
        end
        else if (avg_reg > pssc_pkg::CORNER_LIM)
        begin
            kind = pssc_pkg::KIND_CORNER;
        end
        else
        begin
            kind = pssc_pkg::KIND_UNKNOWN;
        end
    end

    assign rec_stat.ready = (state_reg == R_IDLE);
    assign sec.valid      = out_valid_reg;

    always_ff @(posedge clk)
    begin
        case (state_reg)
            R_IDLE:
            begin
                if (rec_req.start)
                begin
                    job_reg <= rec_req.job;
                    dvd_reg <= pssc_pkg::SQ_W'(rec_req.job.sum);
                    rem_reg <= '0;
                    cnt_reg <= DCNT_W'(pssc_pkg::SQ_W - 1);
                end
            end
            R_DIV1:
            begin
                rem_reg <= rem_n;
                dvd_reg <= dvd_n;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    avg_reg <= dvd_n[pssc_pkg::CURV_W-1:0];
                    dvd_reg <= job_reg.sumsq;
                    rem_reg <= '0;
                    cnt_reg <= DCNT_W'(pssc_pkg::SQ_W - 1);
                end
            end
            R_DIV2:
            begin
                rem_reg <= rem_n;
                dvd_reg <= dvd_n;
                cnt_reg <= cnt_reg - 1'b1;
            end
            R_SQ:
            begin
                avgsq_reg <= avg_reg * avg_reg;
            end
            R_OUT:
            begin
                if (out_free)
                begin
                    sec.first_index    <= job_reg.first;
                    sec.final_index    <= job_reg.last_idx;
                    sec.start_dist_mm  <= job_reg.start_dist;
                    sec.end_dist_mm    <= job_reg.end_dist;
                    sec.span_mm        <= job_reg.end_dist - job_reg.start_dist;
                    sec.mean_abs_curv  <= avg_reg;
                    sec.peak_abs_curv  <= job_reg.cmax;
                    sec.least_abs_curv <= job_reg.cmin;
                    sec.sector_kind    <= kind;
                    sec.last_sector    <= job_reg.last;
                end
            end
            default:
            begin
                avg_reg <= avg_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= R_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sec.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                R_IDLE:
                begin
                    if (rec_req.start)
                    begin
                        state_reg <= R_DIV1;
                    end
                end
                R_DIV1:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= R_DIV2;
                    end
                end
                R_DIV2:
                begin
                    if (cnt_reg == '0)
                    begin
                        state_reg <= R_SQ;
                    end
                end
                R_SQ:
                begin
                    state_reg <= R_OUT;
                end
                R_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= R_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= R_IDLE;
                end
            endcase
        end
    end

endmodule
